FILE: rtl/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg: shared types for the box difference pipeline
// Corner vectors, box and box-pair layouts, per-axis cut flags and slot masks.
// ----------------------------------------------------------------------------
package bds_pkg;

  // number of axes carried on the ports and coordinate width
  localparam int unsigned AXES  = 3;
  localparam int unsigned CW    = 32;
  // one low slab and one high slab per axis
  localparam int unsigned SLOTS = 2 * AXES;

  localparam int unsigned BOX_W  = 2 * AXES * CW;
  localparam int unsigned PAIR_W = 2 * BOX_W;

  typedef logic signed [CW-1:0] coord_t;

  // lo corner in the low bits, x lowest
  typedef struct packed {
    coord_t [AXES-1:0] hi;
    coord_t [AXES-1:0] lo;
  } box_t;

  // box a in the low bits, box b above it
  typedef struct packed {
    box_t b;
    box_t a;
  } pair_t;

  // per-axis slab cuts and whole-box relations
  typedef struct packed {
    logic [AXES-1:0] lo_cut;
    logic [AXES-1:0] hi_cut;
    logic            contained;
    logic            meet;
  } cls_t;

  typedef logic [SLOTS-1:0] mask_t;
  typedef box_t [SLOTS-1:0] slots_t;

endpackage

FILE: rtl/bds_classify.sv
// ----------------------------------------------------------------------------
// bds_classify: first pipeline stage
// Registers the box pair and the comparisons that decide containment,
// overlap and which slabs get cut on every axis.
// ----------------------------------------------------------------------------
module bds_classify #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bds_pkg::pair_t in_pair_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bds_pkg::pair_t out_pair_o,
  output bds_pkg::cls_t  out_cls_o
);
  import bds_pkg::*;

  logic  valid_q, valid_d;
  pair_t pair_q;
  cls_t  cls_q, cls_d;
  logic  take;

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // per-axis comparisons, axes above DIMENSIONS take no part
  always_comb begin
    coord_t alo, ahi, blo, bhi;
    logic   lc;
    cls_d.contained = 1'b1;
    cls_d.meet      = 1'b1;
    cls_d.lo_cut    = '0;
    cls_d.hi_cut    = '0;
    for (int d = 0; d < int'(AXES); d++) begin
      alo = in_pair_i.a.lo[d];
      ahi = in_pair_i.a.hi[d];
      blo = in_pair_i.b.lo[d];
      bhi = in_pair_i.b.hi[d];
      lc  = ($signed(alo) < $signed(blo)) && ($signed(blo) <= $signed(ahi));
      if (d < int'(DIMENSIONS)) begin
        if (!(($signed(blo) <= $signed(alo)) && ($signed(ahi) <= $signed(bhi)))) begin
          cls_d.contained = 1'b0;
        end
        // larger low above smaller high means no overlap
        if (!(($signed(alo) <= $signed(ahi)) && ($signed(alo) <= $signed(bhi)) &&
              ($signed(blo) <= $signed(ahi)) && ($signed(blo) <= $signed(bhi)))) begin
          cls_d.meet = 1'b0;
        end
        cls_d.lo_cut[d] = lc;
        // high cut sees the low corner after the low cut
        cls_d.hi_cut[d] = (lc ? ($signed(blo) <= $signed(bhi))
                              : ($signed(alo) <= $signed(bhi))) &&
                          ($signed(bhi) < $signed(ahi));
      end
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      pair_q <= in_pair_i;
      cls_q  <= cls_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pair_o  = pair_q;
  assign out_cls_o   = cls_q;

endmodule

FILE: rtl/bds_cut.sv
// ----------------------------------------------------------------------------
// bds_cut: second pipeline stage
// Builds the six candidate slabs (z low, z high, y low, ... x high) and a
// mask of those that exist, or the whole box or an empty marker.
// ----------------------------------------------------------------------------
module bds_cut #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bds_pkg::pair_t  in_pair_i,
  input  bds_pkg::cls_t   in_cls_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bds_pkg::slots_t out_slots_o,
  output bds_pkg::mask_t  out_mask_o,
  output logic            out_empty_o
);
  import bds_pkg::*;

  logic   valid_q, valid_d;
  slots_t slots_q, slots_d;
  mask_t  mask_q, mask_d;
  logic   empty_q, empty_d;
  logic   take;

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // slab construction, slot 2k handles the low face of axis AXES-1-k
  always_comb begin
    coord_t [AXES-1:0] nlo, nhi;
    int unsigned       ax;
    for (int d = 0; d < int'(AXES); d++) begin
      nlo[d] = in_cls_i.lo_cut[d] ? in_pair_i.b.lo[d] : in_pair_i.a.lo[d];
      nhi[d] = in_cls_i.hi_cut[d] ? in_pair_i.b.hi[d] : in_pair_i.a.hi[d];
    end
    slots_d = '0;
    mask_d  = '0;
    empty_d = 1'b0;
    for (int j = 0; j < int'(SLOTS); j++) begin
      ax = AXES - 1 - (unsigned'(j) >> 1);
      // axes already worked are narrowed to b, the rest keep a
      for (int d = 0; d < int'(AXES); d++) begin
        if (unsigned'(d) > ax) begin
          slots_d[j].lo[d] = nlo[d];
          slots_d[j].hi[d] = nhi[d];
        end else begin
          slots_d[j].lo[d] = in_pair_i.a.lo[d];
          slots_d[j].hi[d] = in_pair_i.a.hi[d];
        end
      end
      if ((j & 1) == 0) begin
        slots_d[j].hi[ax] = in_pair_i.b.lo[ax] - coord_t'(1);
        mask_d[j]         = in_cls_i.lo_cut[ax];
      end else begin
        slots_d[j].lo[ax] = in_pair_i.b.hi[ax] + coord_t'(1);
        slots_d[j].hi[ax] = in_pair_i.a.hi[ax];
        mask_d[j]         = in_cls_i.hi_cut[ax];
      end
    end
    // whole-box and empty cases override the slab list
    if (in_cls_i.contained) begin
      empty_d = 1'b1;
    end else if (!in_cls_i.meet) begin
      slots_d[0] = in_pair_i.a;
      mask_d     = mask_t'(1);
    end else if (mask_d == '0) begin
      empty_d = 1'b1;
    end
    if (empty_d) begin
      slots_d[0] = '0;
      mask_d     = mask_t'(1);
    end
    // unused axes read as zero
    for (int j = 0; j < int'(SLOTS); j++) begin
      for (int d = 0; d < int'(AXES); d++) begin
        if (d >= int'(DIMENSIONS)) begin
          slots_d[j].lo[d] = '0;
          slots_d[j].hi[d] = '0;
        end
      end
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      slots_q <= slots_d;
      mask_q  <= mask_d;
      empty_q <= empty_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_slots_o = slots_q;
  assign out_mask_o  = mask_q;
  assign out_empty_o = empty_q;

endmodule

FILE: rtl/bds_emit.sv
// ----------------------------------------------------------------------------
// bds_emit: output stage
// Holds one item's slab list and sends its pieces in slot order through a
// registered output, one per cycle unless stalled; flags the final piece.
// ----------------------------------------------------------------------------
module bds_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bds_pkg::slots_t in_slots_i,
  input  bds_pkg::mask_t  in_mask_i,
  input  logic            in_empty_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bds_pkg::box_t   out_box_o,
  output logic            out_empty_o,
  output logic            out_last_o
);
  import bds_pkg::*;

  slots_t slots_q;
  mask_t  mask_q, mask_d;
  logic   empty_q;
  logic   out_valid_q, out_valid_d;
  box_t   out_box_q;
  logic   out_empty_q;
  logic   out_last_q;

  mask_t  pick, rest;
  box_t   sel_box;
  logic   pop, load, take;

  // first pending slot, in slot order
  always_comb begin
    pick    = '0;
    sel_box = '0;
    for (int j = 0; j < int'(SLOTS); j++) begin
      if (mask_q[j] && (pick == '0)) begin
        pick[j] = 1'b1;
        sel_box = slots_q[j];
      end
    end
  end

  assign rest = mask_q & ~pick;
  assign pop  = (mask_q != '0) && (!out_valid_q || out_ready_i);
  // a new item may enter while the final piece of the current one leaves
  assign load = (mask_q == '0) || (pop && (rest == '0));
  assign take = in_valid_i && load;
  assign in_ready_o = load;

  always_comb begin
    mask_d = mask_q;
    if (take) begin
      mask_d = in_mask_i;
    end else if (pop) begin
      mask_d = rest;
    end
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      slots_q <= in_slots_i;
      empty_q <= in_empty_i;
    end
    if (pop) begin
      out_box_q   <= sel_box;
      out_empty_q <= empty_q;
      out_last_q  <= (rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_box_o   = out_box_q;
  assign out_empty_o = out_empty_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/box_difference_slabs_top.sv
// ----------------------------------------------------------------------------
// box_difference_slabs_top: axis-aligned box difference A minus B
// Streams box pairs in and the disjoint pieces covering A minus B out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one box pair per transaction; m_axis carries one piece
//   per transaction, tlast on the final piece of each pair, tuser set when
//   the difference is empty (then a single all-zero piece is sent).
//   Pieces come in order: z low slab, z high slab, y low, y high, x low,
//   x high; a pair that does not overlap gives box A whole.
// Timing:
//   a pair passes the classify, cut and emit hold registers and then the
//   output register. Each pair gives 1 to 6 pieces, which the single
//   output register drains at one piece per cycle while m_axis is not
//   stalled; single-piece pairs stream at one per cycle on the same terms.
// Reset and stall:
//   reset empties every stage; no output is valid afterwards. When m_axis
//   stalls the output register holds its piece and the stages behind it
//   fill up and then drop s_axis_tready; nothing is lost or repeated.
// DIMENSIONS selects the active axes from x upward; unused axes read zero.
// ----------------------------------------------------------------------------
module box_difference_slabs_top #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // a_lo_x, a_lo_y, a_lo_z, a_hi_x, a_hi_y, a_hi_z,
  // b_lo_x, b_lo_y, b_lo_z, b_hi_x, b_hi_y, b_hi_z (32 bits each, from bit 0)
  input  logic [bds_pkg::PAIR_W-1:0]  s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // piece_lo_x, piece_lo_y, piece_lo_z, piece_hi_x, piece_hi_y, piece_hi_z
  // (32 bits each, from bit 0)
  output logic [bds_pkg::BOX_W-1:0]   m_axis_tdata,
  // no_piece
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready
);
  import bds_pkg::*;

  pair_t  s1_pair;
  cls_t   s1_cls;
  logic   s1_valid, s1_ready;
  slots_t s2_slots;
  mask_t  s2_mask;
  logic   s2_empty, s2_valid, s2_ready;
  box_t   out_box;

  // stage 1: comparisons
  bds_classify #(
    .DIMENSIONS(DIMENSIONS)
  ) u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_pair_i  (pair_t'(s_axis_tdata)),
    .out_valid_o(s1_valid),
    .out_ready_i(s1_ready),
    .out_pair_o (s1_pair),
    .out_cls_o  (s1_cls)
  );

  // stage 2: slab list
  bds_cut #(
    .DIMENSIONS(DIMENSIONS)
  ) u_cut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid),
    .in_ready_o (s1_ready),
    .in_pair_i  (s1_pair),
    .in_cls_i   (s1_cls),
    .out_valid_o(s2_valid),
    .out_ready_i(s2_ready),
    .out_slots_o(s2_slots),
    .out_mask_o (s2_mask),
    .out_empty_o(s2_empty)
  );

  // stage 3: piece serializer and output register
  bds_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s2_valid),
    .in_ready_o (s2_ready),
    .in_slots_i (s2_slots),
    .in_mask_i  (s2_mask),
    .in_empty_i (s2_empty),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_box_o  (out_box),
    .out_empty_o(m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = out_box;

endmodule

FILE: verif/box_difference_slabs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_difference_slabs_checker: piece predictor and scoreboard
// Watches both stream channels. Every accepted box pair is cut into its
// expected pieces. Every accepted piece is compared with the oldest expected
// one. Reports the number of failures and the number of pieces still due.
// ----------------------------------------------------------------------------
module box_difference_slabs_checker #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // a_lo_x .. a_hi_z, b_lo_x .. b_hi_z (32 bits each, from bit 0)
  input  logic [bds_pkg::PAIR_W-1:0] s_axis_tdata_i,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_i,
  // piece_lo_x .. piece_hi_z (32 bits each, from bit 0)
  input  logic [bds_pkg::BOX_W-1:0]  m_axis_tdata_i,
  // no_piece
  input  logic                       m_axis_tuser_i,
  input  logic                       m_axis_tlast_i,
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  output int                         fail_count_o,
  output int                         pieces_pending_o
);
  import bds_pkg::*;

  // room for every piece of the pairs that can be in flight at once
  localparam int unsigned DUE_DEPTH = 64;

  typedef struct packed {
    box_t box;
    logic no_piece;
    logic last_piece;
  } piece_t;

  piece_t      due_fifo[DUE_DEPTH];
  int unsigned due_wr = 0;
  int unsigned due_rd = 0;
  piece_t      seen_piece;
  int          fail_count = 0;
  string       axis_tag[AXES] = '{"x", "y", "z"};

  assign fail_count_o = fail_count;

  // one piece from corner vectors; axes above DIMENSIONS read zero
  function automatic piece_t make_piece(input longint lo[AXES], input longint hi[AXES],
                                        input logic empty);
    piece_t pc;
    int     d;
    pc = '0;
    for (d = 0; d < AXES; d++) begin
      if (d < DIMENSIONS) begin
        pc.box.lo[d] = coord_t'(lo[d]);
        pc.box.hi[d] = coord_t'(hi[d]);
      end
    end
    pc.no_piece = empty;
    return pc;
  endfunction

  // append one expected piece to the in-order store
  function automatic void store_due(input piece_t pc);
    if (due_wr - due_rd >= DUE_DEPTH) begin
      $error("expected piece store overflow: %0d pieces due", due_wr - due_rd);
      fail_count++;
      return;
    end
    due_fifo[due_wr % DUE_DEPTH] = pc;
    due_wr++;
  endfunction

  // cut box a by box b into slabs, z axis first, low slab before high slab
  function automatic void predict_pieces(input pair_t p);
    longint alo[AXES], ahi[AXES], blo[AXES], bhi[AXES];
    longint plo[AXES], phi[AXES];
    longint zero[AXES];
    longint lo_max, hi_min;
    logic   contained, meet;
    piece_t made[SLOTS];
    int     n_made;
    int     d, i, k;
    contained = 1'b1;
    meet      = 1'b1;
    n_made    = 0;
    for (d = 0; d < AXES; d++) begin
      alo[d]  = longint'($signed(p.a.lo[d]));
      ahi[d]  = longint'($signed(p.a.hi[d]));
      blo[d]  = longint'($signed(p.b.lo[d]));
      bhi[d]  = longint'($signed(p.b.hi[d]));
      zero[d] = 0;
    end
    // containment and overlap over the active axes
    for (d = 0; d < DIMENSIONS && d < AXES; d++) begin
      lo_max = (alo[d] > blo[d]) ? alo[d] : blo[d];
      hi_min = (ahi[d] < bhi[d]) ? ahi[d] : bhi[d];
      if (!(blo[d] <= alo[d] && ahi[d] <= bhi[d])) contained = 1'b0;
      if (lo_max > hi_min) meet = 1'b0;
    end
    if (!contained) begin
      if (!meet) begin
        made[0] = make_piece(alo, ahi, 1'b0);
        n_made  = 1;
      end else begin
        for (i = int'(DIMENSIONS) - 1; i >= 0; i--) begin
          if (i < AXES) begin
            // slab below b's low face
            if (alo[i] < blo[i] && blo[i] <= ahi[i] && n_made < SLOTS) begin
              plo = alo;
              phi = ahi;
              phi[i] = blo[i] - 1;
              made[n_made] = make_piece(plo, phi, 1'b0);
              n_made++;
              alo[i] = blo[i];
            end
            // slab above b's high face
            if (alo[i] <= bhi[i] && bhi[i] < ahi[i] && n_made < SLOTS) begin
              plo = alo;
              phi = ahi;
              plo[i] = bhi[i] + 1;
              made[n_made] = make_piece(plo, phi, 1'b0);
              n_made++;
              ahi[i] = bhi[i];
            end
          end
        end
      end
    end
    // empty difference gives a single zero piece
    if (n_made == 0) begin
      made[0] = make_piece(zero, zero, 1'b1);
      n_made  = 1;
    end
    made[n_made - 1].last_piece = 1'b1;
    for (k = 0; k < n_made; k++) store_due(made[k]);
  endfunction

  // field by field compare against the oldest expected piece
  function automatic void check_piece(input piece_t got);
    piece_t want;
    int     d;
    if (due_wr == due_rd) begin
      $error("piece with no pair waiting: lo_x %0d hi_x %0d no_piece %0b last_piece %0b",
             $signed(got.box.lo[0]), $signed(got.box.hi[0]), got.no_piece, got.last_piece);
      fail_count++;
      return;
    end
    want = due_fifo[due_rd % DUE_DEPTH];
    due_rd++;
    for (d = 0; d < AXES; d++) begin
      if (got.box.lo[d] !== want.box.lo[d]) begin
        $error("piece_lo_%s: expected %0d, got %0d", axis_tag[d],
               $signed(want.box.lo[d]), $signed(got.box.lo[d]));
        fail_count++;
      end
      if (got.box.hi[d] !== want.box.hi[d]) begin
        $error("piece_hi_%s: expected %0d, got %0d", axis_tag[d],
               $signed(want.box.hi[d]), $signed(got.box.hi[d]));
        fail_count++;
      end
    end
    if (got.no_piece !== want.no_piece) begin
      $error("no_piece: expected %0b, got %0b", want.no_piece, got.no_piece);
      fail_count++;
    end
    if (got.last_piece !== want.last_piece) begin
      $error("last_piece: expected %0b, got %0b", want.last_piece, got.last_piece);
      fail_count++;
    end
  endfunction

  // predict on every input transaction, compare on every output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) predict_pieces(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen_piece.box        = m_axis_tdata_i;
        seen_piece.no_piece   = m_axis_tuser_i;
        seen_piece.last_piece = m_axis_tlast_i;
        check_piece(seen_piece);
      end
    end
    pieces_pending_o <= int'(due_wr - due_rd);
  end

endmodule

FILE: verif/box_difference_slabs_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_difference_slabs_top_tb: stream testbench for the box difference block
// Drives directed box pairs (containment, disjoint, touching faces, extreme
// and malformed corners), then random pairs that mostly overlap. Sender and
// receiver stall at random in two phases, not the third. The checker predicts
// and compares the pieces. The final verdict comes from its failure count.
// ----------------------------------------------------------------------------
module box_difference_slabs_top_tb;
  import bds_pkg::*;

  localparam int unsigned DIMS            = 3;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned TAIL_CYCLES     = 24;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int          COORD_MIN       = int'(32'h8000_0000);
  localparam int          COORD_MAX       = int'(32'h7fff_ffff);

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  pair_t             s_tdata  = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BOX_W-1:0]  m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  int unsigned       src_idle_pct = 13;
  int unsigned       snk_idle_pct = 62;
  int                fail_count;
  int                pieces_pending;
  int unsigned       cycle_cnt = 0;

  box_difference_slabs_top #(
    .DIMENSIONS(DIMS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready)
  );

  box_difference_slabs_checker #(
    .DIMENSIONS(DIMS)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tuser_i   (m_tuser),
    .m_axis_tlast_i   (m_tlast),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .fail_count_o     (fail_count),
    .pieces_pending_o (pieces_pending)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic box_t mk_box(input int lx, input int ly, input int lz,
                                  input int hx, input int hy, input int hz);
    box_t bx;
    bx.lo[0] = lx;
    bx.lo[1] = ly;
    bx.lo[2] = lz;
    bx.hi[0] = hx;
    bx.hi[1] = hy;
    bx.hi[2] = hz;
    return bx;
  endfunction

  // one input transaction, with random sender gaps in front of it
  task automatic send_pair(input pair_t p);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_boxes(input box_t a, input box_t b);
    pair_t p;
    p.a = a;
    p.b = b;
    send_pair(p);
  endtask

  // hold off the sender until every expected piece has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pieces_pending != 0) @(posedge clk_i);
  endtask

  // random pair: mostly overlapping boxes near a random base, some noise,
  // some containment and some malformed corners
  function automatic pair_t random_pair();
    pair_t       p;
    int unsigned kind, span, base, sel, d;
    int          a0, a1, b0, b1, floor_b1;
    coord_t      swap_c;
    kind = $urandom_range(99, 0);
    span = $urandom_range(40, 1);
    sel  = $urandom_range(19, 0);
    if (sel == 0) base = 32'h8000_0000;
    else if (sel == 1) base = 32'h7fff_ffff - span;
    else base = $urandom;
    // full-width noise
    if (kind < 12) begin
      for (d = 0; d < AXES; d++) begin
        p.a.lo[d] = $urandom;
        p.a.hi[d] = $urandom;
        p.b.lo[d] = $urandom;
        p.b.hi[d] = $urandom;
      end
      return p;
    end
    for (d = 0; d < AXES; d++) begin
      a0 = $urandom_range(span, 0);
      a1 = $urandom_range(span, a0);
      if (kind < 22) begin
        // b contains a
        b0 = a0 - int'($urandom_range(3, 0));
        b1 = a1 + int'($urandom_range(3, 0));
      end else if ($urandom_range(99, 0) < 85) begin
        // b meets a on this axis
        b0 = int'($urandom_range(a1 + 2, 0)) - 2;
        floor_b1 = (b0 > a0) ? b0 : a0;
        b1 = $urandom_range(span + 3, floor_b1);
      end else begin
        b0 = $urandom_range(span, 0);
        b1 = $urandom_range(span, b0);
      end
      p.a.lo[d] = base + a0;
      p.a.hi[d] = base + a1;
      p.b.lo[d] = base + b0;
      p.b.hi[d] = base + b1;
    end
    // malformed corners on one axis of one box
    if (kind >= 22 && kind < 30) begin
      d = $urandom_range(AXES - 1, 0);
      if ($urandom_range(1, 0) == 0) begin
        swap_c = p.a.lo[d];
        p.a.lo[d] = p.a.hi[d] + 1;
        p.a.hi[d] = swap_c;
      end else begin
        swap_c = p.b.lo[d];
        p.b.lo[d] = p.b.hi[d] + 1;
        p.b.hi[d] = swap_c;
      end
    end
    return p;
  endfunction

  // stimulus and verdict
  initial begin
    int unsigned phase, n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // b contains a, and a equal to b
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(-5, -5, -5, 20, 20, 20));
    send_boxes(mk_box(3, 4, 5, 6, 7, 8), mk_box(3, 4, 5, 6, 7, 8));
    // disjoint, touching faces, adjacent faces
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(20, 0, 0, 30, 9, 9));
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(9, -1, -1, 20, 10, 10));
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(10, -1, -1, 20, 10, 10));
    // b strictly inside a gives all six slabs
    send_boxes(mk_box(0, 0, 0, 99, 99, 99), mk_box(10, 10, 10, 20, 20, 20));
    // single slabs on one axis, and both y slabs
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(5, -1, -1, 20, 10, 10));
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(-1, -1, -5, 10, 10, 4));
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(-1, 3, -1, 10, 5, 10));
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(0, 0, 0, 9, 9, 8));
    // unit boxes
    send_boxes(mk_box(0, 0, 0, 2, 2, 2), mk_box(1, 1, 1, 1, 1, 1));
    send_boxes(mk_box(7, 7, 7, 7, 7, 7), mk_box(0, 0, 0, 9, 9, 9));
    // negative corners
    send_boxes(mk_box(-100, -100, -100, -50, -50, -50), mk_box(-80, -120, -60, -60, -70, 0));
    // full coordinate range
    send_boxes(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
               mk_box(0, 0, 0, 0, 0, 0));
    send_boxes(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
               mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_boxes(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
               mk_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
    send_boxes(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
               mk_box(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
    send_boxes(mk_box(COORD_MAX - 1, 0, 0, COORD_MAX, 1, 1),
               mk_box(COORD_MAX, -1, -1, COORD_MAX, 2, 2));
    // malformed a, malformed b, and both malformed with b containing a
    send_boxes(mk_box(5, 0, 0, 0, 9, 9), mk_box(0, 0, 0, 9, 9, 9));
    send_boxes(mk_box(0, 0, 0, 9, 9, 9), mk_box(9, 0, 0, 0, 9, 9));
    send_boxes(mk_box(5, 0, 0, 0, 9, 9), mk_box(3, -1, -1, 2, 10, 10));

    // random pairs over three stall profiles
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct <= 62;
        snk_idle_pct <= 13;
      end else if (phase == 2) begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_drained();
        send_pair(random_pair());
      end
    end

    // drain and settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
